### rtl/lcg48_pkg.sv
// Shared constants and controller/datapath interface types for the 48-bit LCG source.
package lcg48_pkg;

  localparam int unsigned STATE_W = 48;
  localparam int unsigned MULT_W  = 35;
  localparam int unsigned DRAW_W  = 31;

  localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5DEECE66D;
  localparam logic [STATE_W-1:0] LCG_ADD  = 48'hB;

  localparam logic REQ_RAW     = 1'b0;
  localparam logic REQ_BOUNDED = 1'b1;

  localparam logic [5:0] MAX_BITS = 6'd32;
  localparam logic [4:0] DIV_LAST = 5'd30;

  typedef struct packed {
    logic accept;
    logic mul;
    logic add;
    logic div_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic no_div;
    logic div_last;
    logic chk_ok;
  } sts_t;

endpackage

### rtl/lcg48_dp.sv
// Datapath: generator state, split constant multiply, serial remainder and result select.
module lcg48_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [63:0]           cfg_data,
  input  logic                  req_type,
  input  logic [5:0]            bit_count,
  input  logic signed [31:0]    bound,
  input  lcg48_pkg::cmd_t       cmd,
  output lcg48_pkg::sts_t       st,
  output logic [31:0]           value,
  output logic                  bad_bound
);

  logic [lcg48_pkg::STATE_W-1:0] lcg_state;
  logic [lcg48_pkg::STATE_W-1:0] pa;
  logic [23:0]                   pb;
  logic [58:0]                   prod_lo;
  logic [47:0]                   prod_hi;

  logic        req_q;
  logic [5:0]  nbits_q;
  logic [31:0] bound_q;
  logic        bad_q;
  logic        pow2_q;

  logic [31:0] rem;
  logic [30:0] dvd;
  logic [4:0]  div_cnt;
  logic [31:0] shifted;
  logic [31:0] trial;

  logic [30:0] r31;
  logic [5:0]  nsat;
  logic [5:0]  sh;
  logic [31:0] raw_val;
  logic [31:0] pow_val;
  logic [32:0] chk;
  logic [31:0] res_val;
  logic [31:0] bound_m1;

  assign prod_lo = {24'd0, lcg_state[23:0]} * {24'd0, lcg48_pkg::LCG_MULT};
  assign prod_hi = {24'd0, lcg_state[47:24]} * {24'd0, lcg48_pkg::LCG_MULT[23:0]};

  assign bound_m1 = bound - 32'sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= {13'd0, lcg48_pkg::LCG_MULT};
    end else if (cfg_we) begin
      lcg_state <= cfg_data[47:0] ^ {13'd0, lcg48_pkg::LCG_MULT};
    end else if (cmd.add) begin
      lcg_state <= pa + {pb, 24'd0} + lcg48_pkg::LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa <= prod_lo[47:0];
      pb <= prod_hi[23:0];
    end
    if (cmd.accept) begin
      req_q   <= req_type;
      nbits_q <= bit_count;
      bound_q <= bound;
      bad_q   <= (req_type == lcg48_pkg::REQ_BOUNDED) && (bound[31] || (bound == 32'sd0));
      pow2_q  <= ((bound & bound_m1) == 32'sd0);
    end
  end

  // restoring remainder, one bit a cycle
  assign shifted = {rem[30:0], dvd[30]};
  assign trial   = shifted - {1'b0, bound_q[30:0]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem     <= 32'd0;
      dvd     <= r31;
      div_cnt <= 5'd0;
    end else if (cmd.div_step) begin
      rem     <= (shifted >= {1'b0, bound_q[30:0]}) ? trial : shifted;
      dvd     <= {dvd[29:0], 1'b0};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  assign r31 = lcg_state[47:17];

  always_comb begin
    nsat    = (nbits_q > lcg48_pkg::MAX_BITS) ? lcg48_pkg::MAX_BITS : nbits_q;
    sh      = lcg48_pkg::MAX_BITS - nsat;
    raw_val = lcg_state[47:16] >> sh;
  end

  always_comb begin
    pow_val = 32'd0;
    for (int i = 0; i < 31; i++) begin
      if (bound_q[i]) begin
        pow_val = pow_val | ({1'b0, r31} >> (31 - i));
      end
    end
  end

  assign chk = {2'b0, r31} - {2'b0, rem[30:0]} + {2'b0, bound_q[30:0]} - 33'd1;

  always_comb begin
    if (bad_q) begin
      res_val = 32'd0;
    end else if (req_q == lcg48_pkg::REQ_RAW) begin
      res_val = raw_val;
    end else if (pow2_q) begin
      res_val = pow_val;
    end else begin
      res_val = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      value     <= res_val;
      bad_bound <= bad_q;
    end
  end

  assign st.bad      = bad_q;
  assign st.no_div   = (req_q == lcg48_pkg::REQ_RAW) || pow2_q;
  assign st.div_last = (div_cnt == lcg48_pkg::DIV_LAST);
  assign st.chk_ok   = (chk[32:31] == 2'b00);

endmodule

### rtl/lcg48_ctrl.sv
// Controller: request sequencing, redraw loop and output beat handshake.
module lcg48_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  lcg48_pkg::sts_t st,
  output lcg48_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_ADD   = 7'b0000100,
    S_DIVLD = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = st.bad ? S_DONE : S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = st.no_div ? S_DONE : S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = st.chk_ok ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_add_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |=> (state == S_DIVLD || state == S_DONE))
    else $error("bad state after state update");

  a_bad_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && st.bad) |=> (state == S_DONE))
    else $error("bad bound did not skip draw");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !cmd.load_out) |=> !out_valid)
    else $error("output beat not dropped after take");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && st.div_last) |=> (state == S_CHK))
    else $error("divider did not end");

endmodule

### rtl/lcg48_random_source.sv
// Top level of the 48-bit linear congruential random source.
// Raw and power-of-two requests pass multiply and add, then load the result; a bad bound skips
// from multiply to the load; other bounds run divider load, serial remainder and check before the
//   load, and each rejected draw goes back to the multiply. Next beat is taken in the cycle after the result loads.
// Output register holds the result while the sink stalls; a new beat is taken meanwhile.
// Reset: synchronous, state reloads to the scramble of seed 0, no output pending.
module lcg48_random_source (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [5:0]         bit_count,
  input  logic signed [31:0] bound,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        value,
  output logic               bad_bound
);

  lcg48_pkg::cmd_t cmd;
  lcg48_pkg::sts_t st;

  lcg48_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  lcg48_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .bit_count (bit_count),
    .bound     (bound),
    .cmd       (cmd),
    .st        (st),
    .value     (value),
    .bad_bound (bad_bound)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the 48-bit LCG random source: directed table, then random beats.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_BEATS = 250;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic [31:0] value;
    logic        bad;
  } draw_result_t;

  typedef struct {
    logic        req;
    logic [5:0]  nbits;
    logic [31:0] limit;
    logic        fixed;
    logic [31:0] value;
    logic        bad;
  } draw_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [63:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [5:0]         bit_count;
  logic signed [31:0] bound;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        value;
  logic               bad_bound;

  logic [lcg48_pkg::STATE_W-1:0] gen_state;
  draw_result_t       pending_draws[$];
  int unsigned        mismatches = 0;
  int unsigned        cycles = 0;
  bit                 calm = 1'b0;
  bit                 hold_request = 1'b0;

  draw_row_t directed_rows [20] = '{
    '{lcg48_pkg::REQ_RAW,     6'd32, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_RAW,     6'd1,  32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_RAW,     6'd24, 32'h8000_0000, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_RAW,     6'd0,  32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_RAW,     6'd33, 32'h0000_0001, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_RAW,     6'd63, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_RAW,     6'd31, 32'h5555_5555, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd0,  32'h0000_0000, 1'b1, 32'd0, 1'b1},
    '{lcg48_pkg::REQ_BOUNDED, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h8000_0000, 1'b1, 32'd0, 1'b1},
    '{lcg48_pkg::REQ_BOUNDED, 6'd1,  32'h0000_0001, 1'b1, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h0000_0002, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h4000_0000, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h0000_0003, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h4000_0001, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h6000_0000, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'h0000_000A, 1'b0, 32'd0, 1'b0},
    '{lcg48_pkg::REQ_BOUNDED, 6'd32, 32'hC000_0000, 1'b1, 32'd0, 1'b1},
    '{lcg48_pkg::REQ_RAW,     6'd16, 32'hAAAA_AAAA, 1'b0, 32'd0, 1'b0}
  };

  lcg48_random_source dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .bit_count (bit_count),
    .bound     (bound),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .bad_bound (bad_bound)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] draw_bits(input logic [5:0] nbits);
    int unsigned n;
    gen_state = gen_state * {13'd0, lcg48_pkg::LCG_MULT} + lcg48_pkg::LCG_ADD;
    if (nbits == 6'd0) return 32'd0;
    n = (nbits > lcg48_pkg::MAX_BITS) ? 32 : int'(nbits);
    return 32'(gen_state >> (lcg48_pkg::STATE_W - n));
  endfunction

  function automatic draw_result_t predict_draw(input logic req, input logic [5:0] nbits,
                                                input logic [31:0] limit);
    draw_result_t res;
    logic [63:0]  prod;
    logic [31:0]  r;
    logic [31:0]  rem;
    logic [63:0]  chk;
    bit           done;
    res = '0;
    done = 1'b0;
    if (req == lcg48_pkg::REQ_RAW) begin
      res.value = draw_bits(nbits);
    end else if (limit == 32'd0 || limit[31]) begin
      res.bad = 1'b1;
    end else if ((limit & (limit - 32'd1)) == 32'd0) begin
      r = draw_bits(6'(lcg48_pkg::DRAW_W));
      prod = {32'd0, limit} * {32'd0, r};
      res.value = prod[62:31];
    end else begin
      while (!done) begin
        r = draw_bits(6'(lcg48_pkg::DRAW_W));
        rem = r % limit;
        chk = {32'd0, r} - {32'd0, rem} + {32'd0, limit} - 64'd1;
        if (chk <= 64'h7FFF_FFFF) begin
          res.value = rem;
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic offer_beat(input logic req, input logic [5:0] nbits, input logic [31:0] limit,
                            input logic fixed, input draw_result_t fixed_res);
    draw_result_t guess;
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    bit_count <= nbits;
    bound     <= limit;
    do @(posedge clk); while (in_stall);
    guess = predict_draw(req, nbits, limit);
    pending_draws.push_back(fixed ? fixed_res : guess);
  endtask

  task automatic random_beat();
    logic        req;
    logic [5:0]  nbits;
    logic [31:0] limit;
    int unsigned pick;
    pick  = $urandom_range(99);
    nbits = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32, 1));
    limit = $urandom;
    req   = lcg48_pkg::REQ_BOUNDED;
    if (pick < 30) begin
      req = lcg48_pkg::REQ_RAW;
    end else if (pick < 40) begin
      case ($urandom_range(2))
        0: limit = 32'd0;
        1: limit = limit | 32'h8000_0000;
        default: limit = 32'h8000_0000;
      endcase
    end else if (pick < 58) begin
      limit = 32'd1 << $urandom_range(30);
    end else if (pick < 70) begin
      limit = $urandom_range(100, 2);
    end else if (pick < 82) begin
      limit = 32'h4000_0000 + $urandom_range(32'h1000, 1);
    end else begin
      limit = $urandom_range(32'h7FFF_FFFF, 1);
    end
    offer_beat(req, nbits, limit, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] seed);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_state = seed[lcg48_pkg::STATE_W-1:0] ^ {13'd0, lcg48_pkg::LCG_MULT};
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 36);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        $display("%0t unexpected beat: value %h bad_bound %b", $time, value, bad_bound);
        mismatches++;
      end else begin
        if (value !== pending_draws[0].value) begin
          $display("%0t value: expected %h actual %h", $time, pending_draws[0].value, value);
          mismatches++;
        end
        if (bad_bound !== pending_draws[0].bad) begin
          $display("%0t bad_bound: expected %b actual %b", $time, pending_draws[0].bad,
                   bad_bound);
          mismatches++;
        end
        void'(pending_draws.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lcg48_random_source verification failed");
      $finish;
    end
  end

  initial begin
    logic [63:0]  seeds [6];
    draw_result_t row_res;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    req_type  <= lcg48_pkg::REQ_RAW;
    bit_count <= '0;
    bound     <= '0;
    gen_state = {13'd0, lcg48_pkg::LCG_MULT};
    seeds[0] = 64'h0;
    seeds[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[2] = 64'h0000_0005_DEEC_E66D;
    seeds[3] = 64'hFFFF_0000_0000_0000;
    seeds[4] = {$urandom, $urandom};
    seeds[5] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row_res.value = directed_rows[i].value;
      row_res.bad   = directed_rows[i].bad;
      offer_beat(directed_rows[i].req, directed_rows[i].nbits, directed_rows[i].limit,
                 directed_rows[i].fixed, row_res);
    end

    for (int p = 0; p < 6; p++) begin
      load_seed(seeds[p]);
      calm = (p == 2);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 1 && k == 20) hold_request = 1'b1;
        if (p == 3 && k == PHASE_BEATS / 2) drain();
        random_beat();
      end
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("lcg48_random_source verification clean");
    end else begin
      $display("lcg48_random_source verification failed");
    end
    $finish;
  end

endmodule

### lcg48_random_source.f
rtl/lcg48_pkg.sv
rtl/lcg48_dp.sv
rtl/lcg48_ctrl.sv
rtl/lcg48_random_source.sv
dv/testbench.sv
